FILE: hw/rtl/ffsa_pkg.sv
`default_nettype none
package ffsa_pkg;

  localparam int unsigned POOL_BITS = 17;
  localparam int unsigned LEN_W     = POOL_BITS;
  localparam int unsigned ADDR_W    = 17;
  localparam int unsigned SLOT_W    = 9;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned BIT_W     = 4;
  localparam int unsigned SEG_IDX_W = 8;

  localparam int unsigned DEF_MAX_SEGMENTS    = 16;
  localparam int unsigned DEF_MAX_CLASS_SLOTS = 256;

  localparam logic [SLOT_W-1:0] RST_CACHE_SLOTS = SLOT_W'(16);
  localparam logic [LEN_W-1:0]  RST_POOL_SIZE   = LEN_W'(4096);
  localparam logic [LEN_W-1:0]  POOL_LIMIT      = LEN_W'(1) << (POOL_BITS - 1);

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_IGNORED  = 2'd2
  } status_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

  typedef enum logic {
    CFG_CACHE_SLOTS = 1'b0,
    CFG_POOL_SIZE   = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SEG_NOP,
    SEG_MARK,
    SEG_INSERT,
    SEG_MERGE
  } seg_op_e;

  typedef struct packed {
    seg_op_e                op;
    logic [SEG_IDX_W-1:0]   idx;
    logic [LEN_W-1:0]       len_a;
    logic [LEN_W-1:0]       len_b;
    logic                   busy;
  } seg_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_CLS_DIV,
    ST_PA_SCAN,
    ST_PF_SCAN,
    ST_PF_PREV,
    ST_PF_NEXT,
    ST_OUT
  } state_e;

  // pool size clamped to one byte at least and the pool limit at most
  function automatic logic [LEN_W-1:0] eff_pool(input logic [LEN_W-1:0] p);
    if (p == '0) begin
      return LEN_W'(1);
    end else if (p > POOL_LIMIT) begin
      return POOL_LIMIT;
    end
    return p;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/first_fit_segment_allocator_core.sv
`default_nettype none
// sequencing: a hinted class alloc reads and rewrites one slot-map row, a slot free first
//   steps over the class regions one by one, a class scan reads slot-map rows in turn, and a
//   pool alloc or pool free visits segments in turn (a pool free then merges a free left and
//   a free right neighbour); an out-of-range free or a size zero goes straight to the result
// one item at a time; a stalled result holds the sequencer in its last state
// reset: async active low; allocator empty, cache_slots 16, pool_size 4096, no clearing pass
module first_fit_segment_allocator_core #(
  parameter int unsigned MAX_SEGMENTS    = ffsa_pkg::DEF_MAX_SEGMENTS,
  parameter int unsigned MAX_CLASS_SLOTS = ffsa_pkg::DEF_MAX_CLASS_SLOTS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // req_size [16:0], free_address [33:17], zero pad
  input  wire logic        s_axis_tuser,   // req_type
  // result channel
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata,   // result_address [16:0], zero pad
  output logic      [1:0]  m_axis_tuser,   // status
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [16:0] cfg_data_i
);
  import ffsa_pkg::*;

  // slot map geometry: one 16-bit word per row, three class regions in one ram
  localparam int unsigned SCAP   = (MAX_CLASS_SLOTS > 511) ? 511 : MAX_CLASS_SLOTS;
  localparam int unsigned ROWS   = (SCAP + WORD_W - 1) / WORD_W;
  localparam int unsigned DEPTH  = 3 * ROWS;
  localparam int unsigned RAW    = $clog2(DEPTH);
  localparam int unsigned RCNT_W = $clog2(ROWS + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W  = $clog2(MAX_SEGMENTS + 1);

  function automatic logic [RAW-1:0] row_addr(input logic [1:0] c, input int row);
    return RAW'(int'(c) * ROWS + row);
  endfunction

  // configuration
  logic [SLOT_W-1:0] cache_q;
  logic [LEN_W-1:0]  pool_q;
  logic              cfg_fire;

  // sequencer and working registers
  state_e            state_q, state_d;
  req_e              type_q;
  logic [LEN_W-1:0]  size_q;
  logic [ADDR_W-1:0] fa_q;
  logic [1:0]        cls_q, cls_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [RCNT_W-1:0] r_q, r_d;
  logic [CNT_W-1:0]  i_q, i_d;
  logic [ADDR_W-1:0] start_q, start_d;
  logic [ADDR_W-1:0] off_q, off_d;
  logic [ADDR_W-1:0] rem_q, rem_d;
  logic [LEN_W-1:0]  cur_len_q, cur_len_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  status_e           res_stat_q, res_stat_d;

  // output register
  logic              m_valid_q;
  logic [ADDR_W-1:0] m_addr_q;
  status_e           m_stat_q;
  logic              out_load;

  // last-freed hints
  logic              hint_v_q [3];
  logic              hint_v_d [3];
  logic [SLOT_W-1:0] hint_s_q [3];
  logic [SLOT_W-1:0] hint_s_d [3];

  // slot map ram and row valid bits
  logic [DEPTH-1:0]  rv_q;
  logic              rv_rd_q;
  logic              ram_we;
  logic [RAW-1:0]    ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata, word;

  // segment table port
  seg_cmd_t          seg_cmd;
  logic [CNT_W-1:0]  rd_sel;
  logic [LEN_W-1:0]  rd_len;
  logic              rd_busy;
  logic [CNT_W-1:0]  seg_count;

  // derived arena layout
  logic [SLOT_W-1:0] eff_s;
  logic [ADDR_W-1:0] s_ext, two_s, base, lim, cls_off;
  logic [RCNT_W-1:0] rows_needed;

  // decision flags
  logic              cls_hit, hint_ok, scan_found, scan_more;
  logic [1:0]        cls_c;
  logic [BIT_W-1:0]  scan_bit;
  logic [WORD_W-1:0] cand;
  logic              pa_end, pa_hit, pa_exact, tbl_full;
  logic              pf_end, pf_hit, prev_free, next_free;
  logic              div_done;

  assign cfg_fire      = cfg_valid_i && cfg_ready_o;
  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid_i;

  assign eff_s   = (cache_q > SLOT_W'(SCAP)) ? SLOT_W'(SCAP) : cache_q;
  assign s_ext   = ADDR_W'(eff_s);
  assign two_s   = s_ext << 1;
  assign base    = s_ext + two_s;
  assign lim     = base + ADDR_W'(eff_pool(pool_q));
  assign rows_needed = RCNT_W'((10'(eff_s) + 10'(WORD_W - 1)) >> BIT_W);

  always_comb begin
    case (cls_q)
      2'd1:    cls_off = s_ext;
      2'd2:    cls_off = two_s;
      default: cls_off = '0;
    endcase
  end

  // size class of an alloc
  always_comb begin
    cls_hit = 1'b1;
    case (size_q)
      LEN_W'(2): cls_c = 2'd0;
      LEN_W'(4): cls_c = 2'd1;
      LEN_W'(8): cls_c = 2'd2;
      default: begin
        cls_c   = 2'd0;
        cls_hit = 1'b0;
      end
    endcase
  end
  assign hint_ok = hint_v_q[cls_c] && (hint_s_q[cls_c] < eff_s);

  // first free slot in the current row, bits at or past S count as taken
  assign word = rv_rd_q ? ram_rdata : '0;
  always_comb begin
    scan_found = 1'b0;
    scan_bit   = '0;
    for (int b = 0; b < WORD_W; b++) begin
      cand[b] = !word[b] && (10'({r_q, BIT_W'(b)}) < 10'(eff_s));
    end
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        scan_found = 1'b1;
        scan_bit   = BIT_W'(b);
      end
    end
  end
  assign scan_more = (r_q + RCNT_W'(1)) < rows_needed;

  assign pa_end    = (i_q >= seg_count);
  assign pa_hit    = !rd_busy && (rd_len >= size_q);
  assign pa_exact  = (rd_len == size_q);
  assign tbl_full  = (seg_count == CNT_W'(MAX_SEGMENTS));
  assign pf_end    = (i_q >= seg_count);
  assign pf_hit    = (start_q == off_q);
  assign prev_free = !rd_busy;
  assign next_free = ((i_q + CNT_W'(1)) < seg_count) && !rd_busy;
  assign div_done  = (rem_q < s_ext);
  assign out_load  = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (type_q == REQ_ALLOC) begin
          if (cls_hit) begin
            if (hint_ok)                    state_d = ST_RMW_RD;
            else if (rows_needed != '0)     state_d = ST_SCAN_RD;
            else                            state_d = ST_PA_SCAN;
          end else if (size_q == '0) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_PA_SCAN;
          end
        end else begin
          if (fa_q >= lim)       state_d = ST_OUT;
          else if (fa_q < base)  state_d = ST_CLS_DIV;
          else                   state_d = ST_PF_SCAN;
        end
      end
      ST_SCAN_RD:  state_d = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (scan_found)      state_d = ST_OUT;
        else if (scan_more)  state_d = ST_SCAN_RD;
        else                 state_d = ST_PA_SCAN;
      end
      ST_RMW_RD:   state_d = ST_RMW_WR;
      ST_RMW_WR:   state_d = ST_OUT;
      ST_CLS_DIV: begin
        if (div_done) state_d = ST_RMW_RD;
      end
      ST_PA_SCAN: begin
        if (pa_end || pa_hit) state_d = ST_OUT;
      end
      ST_PF_SCAN: begin
        if (pf_end)                state_d = ST_OUT;
        else if (pf_hit)           state_d = (i_q == '0) ? ST_PF_NEXT : ST_PF_PREV;
      end
      ST_PF_PREV:  state_d = ST_PF_NEXT;
      ST_PF_NEXT:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath and control outputs
  always_comb begin
    cls_d      = cls_q;
    slot_d     = slot_q;
    r_d        = r_q;
    i_d        = i_q;
    start_d    = start_q;
    off_d      = off_q;
    rem_d      = rem_q;
    cur_len_d  = cur_len_q;
    res_addr_d = res_addr_q;
    res_stat_d = res_stat_q;
    hint_v_d   = hint_v_q;
    hint_s_d   = hint_s_q;
    ram_we     = 1'b0;
    ram_wdata  = word;
    ram_waddr  = row_addr(cls_q, int'(slot_q[SLOT_W-1:BIT_W]));
    ram_raddr  = row_addr(cls_q, int'(slot_q[SLOT_W-1:BIT_W]));
    rd_sel     = i_q;
    seg_cmd    = '{op: SEG_NOP, idx: '0, len_a: '0, len_b: '0, busy: 1'b0};

    case (state_q)
      ST_DISPATCH: begin
        res_addr_d = '0;
        res_stat_d = STAT_DONE;
        r_d        = '0;
        i_d        = '0;
        start_d    = '0;
        off_d      = fa_q - base;
        rem_d      = fa_q;
        if (type_q == REQ_ALLOC) begin
          cls_d  = cls_c;
          slot_d = hint_s_q[cls_c];
          if (cls_hit && hint_v_q[cls_c]) hint_v_d[cls_c] = 1'b0;
          if (!cls_hit && size_q == '0) res_stat_d = STAT_NO_SPACE;
        end else begin
          cls_d = 2'd0;
          if (fa_q >= lim) res_stat_d = STAT_IGNORED;
        end
      end
      ST_SCAN_RD: begin
        ram_raddr = row_addr(cls_q, int'(r_q));
      end
      ST_SCAN_CHK: begin
        ram_waddr = row_addr(cls_q, int'(r_q));
        ram_wdata = word | (WORD_W'(1) << scan_bit);
        if (scan_found) begin
          ram_we     = 1'b1;
          slot_d     = SLOT_W'({r_q, scan_bit});
          res_addr_d = cls_off + ADDR_W'({r_q, scan_bit});
        end else begin
          r_d = r_q + RCNT_W'(1);
        end
      end
      ST_RMW_WR: begin
        ram_we = 1'b1;
        if (type_q == REQ_FREE) begin
          ram_wdata        = word & ~(WORD_W'(1) << slot_q[BIT_W-1:0]);
          hint_v_d[cls_q]  = 1'b1;
          hint_s_d[cls_q]  = slot_q;
        end else begin
          ram_wdata  = word | (WORD_W'(1) << slot_q[BIT_W-1:0]);
          res_addr_d = cls_off + ADDR_W'(slot_q);
        end
      end
      ST_CLS_DIV: begin
        // fold the arena offset into class and slot by repeated subtract
        if (div_done) begin
          slot_d = rem_q[SLOT_W-1:0];
        end else begin
          rem_d = rem_q - s_ext;
          cls_d = cls_q + 2'd1;
        end
      end
      ST_PA_SCAN: begin
        if (pa_end) begin
          res_stat_d = STAT_NO_SPACE;
        end else if (pa_hit) begin
          res_addr_d = base + start_q;
          if (pa_exact) begin
            seg_cmd = '{op: SEG_MARK, idx: SEG_IDX_W'(i_q), len_a: '0, len_b: '0,
                        busy: 1'b1};
          end else if (tbl_full) begin
            res_addr_d = '0;
            res_stat_d = STAT_NO_SPACE;
          end else begin
            seg_cmd = '{op: SEG_INSERT, idx: SEG_IDX_W'(i_q), len_a: size_q,
                        len_b: rd_len - size_q, busy: 1'b1};
          end
        end else begin
          start_d = start_q + ADDR_W'(rd_len);
          i_d     = i_q + CNT_W'(1);
        end
      end
      ST_PF_SCAN: begin
        if (pf_end) begin
          res_stat_d = STAT_IGNORED;
        end else if (pf_hit) begin
          cur_len_d = rd_len;
          seg_cmd   = '{op: SEG_MARK, idx: SEG_IDX_W'(i_q), len_a: '0, len_b: '0,
                        busy: 1'b0};
        end else begin
          start_d = start_q + ADDR_W'(rd_len);
          i_d     = i_q + CNT_W'(1);
        end
      end
      ST_PF_PREV: begin
        rd_sel = i_q - CNT_W'(1);
        if (prev_free) begin
          cur_len_d = rd_len + cur_len_q;
          i_d       = i_q - CNT_W'(1);
          seg_cmd   = '{op: SEG_MERGE, idx: SEG_IDX_W'(i_q - CNT_W'(1)),
                        len_a: rd_len + cur_len_q, len_b: '0, busy: 1'b0};
        end
      end
      ST_PF_NEXT: begin
        rd_sel = i_q + CNT_W'(1);
        if (next_free) begin
          seg_cmd = '{op: SEG_MERGE, idx: SEG_IDX_W'(i_q), len_a: cur_len_q + rd_len,
                      len_b: '0, busy: 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cache_q   <= RST_CACHE_SLOTS;
      pool_q    <= RST_POOL_SIZE;
      m_valid_q <= 1'b0;
      rv_q      <= '0;
      for (int c = 0; c < 3; c++) begin
        hint_v_q[c] <= 1'b0;
        hint_s_q[c] <= '0;
      end
    end else begin
      state_q  <= state_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      // a register write restarts the allocator empty
      if (cfg_fire) begin
        if (cfg_index_i == CFG_CACHE_SLOTS) cache_q <= cfg_data_i[SLOT_W-1:0];
        else                                pool_q  <= cfg_data_i;
        rv_q <= '0;
        for (int c = 0; c < 3; c++) begin
          hint_v_q[c] <= 1'b0;
          hint_s_q[c] <= '0;
        end
      end else begin
        hint_v_q <= hint_v_d;
        hint_s_q <= hint_s_d;
        if (ram_we) rv_q[ram_waddr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      type_q <= req_e'(s_axis_tuser);
      size_q <= s_axis_tdata[16:0];
      fa_q   <= s_axis_tdata[33:17];
    end
    cls_q      <= cls_d;
    slot_q     <= slot_d;
    r_q        <= r_d;
    i_q        <= i_d;
    start_q    <= start_d;
    off_q      <= off_d;
    rem_q      <= rem_d;
    cur_len_q  <= cur_len_d;
    res_addr_q <= res_addr_d;
    res_stat_q <= res_stat_d;
    rv_rd_q    <= rv_q[ram_raddr];
    if (out_load) begin
      m_addr_q <= res_addr_q;
      m_stat_q <= res_stat_q;
    end
  end

  ffsa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ffsa_seg_tbl #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_seg_tbl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (cfg_fire),
    .clear_len_i (eff_pool((cfg_index_i == CFG_POOL_SIZE) ? cfg_data_i : pool_q)),
    .cmd_i       (seg_cmd),
    .rd_idx_i    (rd_sel[IDX_W-1:0]),
    .rd_len_o    (rd_len),
    .rd_busy_o   (rd_busy),
    .count_o     (seg_count)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, m_addr_q};
  assign m_axis_tuser  = m_stat_q;

endmodule
`default_nettype wire

FILE: hw/rtl/ffsa_ram.sv
`default_nettype none
module ffsa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 48
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ffsa_seg_tbl.sv
`default_nettype none
module ffsa_seg_tbl #(
  parameter int unsigned MAX_SEGMENTS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 clear_i,
  input  wire logic [ffsa_pkg::LEN_W-1:0]           clear_len_i,
  input  wire ffsa_pkg::seg_cmd_t                   cmd_i,
  input  wire logic [$clog2(MAX_SEGMENTS)-1:0]      rd_idx_i,
  output logic      [ffsa_pkg::LEN_W-1:0]           rd_len_o,
  output logic                                      rd_busy_o,
  output logic      [$clog2(MAX_SEGMENTS+1)-1:0]    count_o
);
  import ffsa_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);

  logic [LEN_W-1:0] len_q  [MAX_SEGMENTS];
  logic [LEN_W-1:0] len_d  [MAX_SEGMENTS];
  logic             busy_q [MAX_SEGMENTS];
  logic             busy_d [MAX_SEGMENTS];
  logic [CNT_W-1:0] count_q, count_d;

  always_comb begin
    int ci;
    int cn;
    ci = int'(cmd_i.idx);
    cn = int'(count_q);
    len_d   = len_q;
    busy_d  = busy_q;
    count_d = count_q;
    if (clear_i) begin
      for (int j = 0; j < MAX_SEGMENTS; j++) begin
        len_d[j]  = '0;
        busy_d[j] = 1'b0;
      end
      len_d[0] = clear_len_i;
      count_d  = CNT_W'(1);
    end else begin
      case (cmd_i.op)
        SEG_MARK: begin
          busy_d[cmd_i.idx[IDX_W-1:0]] = cmd_i.busy;
        end
        SEG_INSERT: begin
          // busy head at idx, free remainder after it, the rest moves up one
          for (int j = 0; j < MAX_SEGMENTS; j++) begin
            if (j == ci) begin
              len_d[j]  = cmd_i.len_a;
              busy_d[j] = 1'b1;
            end else if (j == ci + 1) begin
              len_d[j]  = cmd_i.len_b;
              busy_d[j] = 1'b0;
            end else if (j > ci + 1 && j <= cn) begin
              len_d[j]  = len_q[j-1];
              busy_d[j] = busy_q[j-1];
            end
          end
          count_d = count_q + CNT_W'(1);
        end
        SEG_MERGE: begin
          // merged free length at idx, entry idx+1 drops out
          for (int j = 0; j < MAX_SEGMENTS; j++) begin
            if (j == ci) begin
              len_d[j]  = cmd_i.len_a;
              busy_d[j] = 1'b0;
            end else if (j > ci && j < cn - 1) begin
              len_d[j]  = len_q[j+1];
              busy_d[j] = busy_q[j+1];
            end else if (j > ci && j == cn - 1) begin
              len_d[j]  = '0;
              busy_d[j] = 1'b0;
            end
          end
          count_d = count_q - CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_SEGMENTS; j++) begin
        len_q[j]  <= (j == 0) ? eff_pool(RST_POOL_SIZE) : '0;
        busy_q[j] <= 1'b0;
      end
      count_q <= CNT_W'(1);
    end else begin
      len_q   <= len_d;
      busy_q  <= busy_d;
      count_q <= count_d;
    end
  end

  assign rd_len_o  = len_q[rd_idx_i];
  assign rd_busy_o = busy_q[rd_idx_i];
  assign count_o   = count_q;

endmodule
`default_nettype wire

FILE: hw/rtl/ffsa_checker.sv
`default_nettype none
module ffsa_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o
);
  import ffsa_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == STAT_DONE || m_axis_tuser == STAT_NO_SPACE ||
                       m_axis_tuser == STAT_IGNORED))
    else $error("bad status code");

  a_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != STAT_DONE |-> m_axis_tdata == '0)
    else $error("address not zero on failed item");

  a_cfg_vs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> !(cfg_valid_i && cfg_ready_o))
    else $error("register write together with an item");

endmodule

bind first_fit_segment_allocator_core ffsa_checker u_ffsa_checker (.*);
`default_nettype wire

FILE: test/first_fit_segment_allocator_core_test.sv
`timescale 1ns / 100ps
module first_fit_segment_allocator_core_test;
  import ffsa_pkg::*;

  typedef struct {
    req_e        kind;
    logic [16:0] size;
    logic [16:0] faddr;
  } request_t;

  typedef struct {
    logic [16:0] addr;
    status_e     status;
  } grant_t;

  localparam int NUM_SEG = 16;
  localparam int NUM_SLOT = 256;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [16:0] cfg_data_i = '0;

  first_fit_segment_allocator_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  // shadow allocator state
  int unsigned cache_slots_q = 16;
  int unsigned pool_size_q = 4096;
  bit          slot_used[3][NUM_SLOT];
  bit          hint_valid[3];
  int          hint_slot[3];
  int          seg_len[NUM_SEG];
  bit          seg_busy[NUM_SEG];
  int          seg_cnt;

  request_t pending_reqs[$];
  grant_t   expected_grants[$];
  int       live_addrs[$];   // addresses granted so far, used to build sensible frees

  int  mismatches = 0;
  int  reqs_sent = 0;
  int  grants_seen = 0;
  int  cfg_writes = 0;
  int  n_alloc_ok = 0, n_no_space = 0, n_ignored = 0;
  bit  no_idle = 0;
  int  quiet_cycles = 0;

  function automatic int slots_eff();
    return (cache_slots_q > NUM_SLOT) ? NUM_SLOT : cache_slots_q;
  endfunction

  function automatic int pool_eff();
    int p;
    p = pool_size_q;
    if (p < 1) p = 1;
    if (p > 65536) p = 65536;
    return p;
  endfunction

  function automatic void restart_empty();
    for (int c = 0; c < 3; c++) begin
      hint_valid[c] = 0;
      hint_slot[c] = 0;
      for (int i = 0; i < NUM_SLOT; i++) slot_used[c][i] = 0;
    end
    for (int i = 0; i < NUM_SEG; i++) begin
      seg_len[i] = 0;
      seg_busy[i] = 0;
    end
    seg_len[0] = pool_eff();
    seg_cnt = 1;
  endfunction

  function automatic bit take_slot(int c, output int slot);
    int n;
    n = slots_eff();
    slot = 0;
    if (hint_valid[c]) begin
      hint_valid[c] = 0;
      if (hint_slot[c] < n) begin
        slot_used[c][hint_slot[c]] = 1;
        slot = hint_slot[c];
        return 1;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (!slot_used[c][i]) begin
        slot_used[c][i] = 1;
        slot = i;
        return 1;
      end
    end
    return 0;
  endfunction

  // first-fit search, split puts the busy part ahead of the free remainder
  function automatic bit take_segment(int sz, output int off);
    int start, i;
    start = 0;
    off = 0;
    if (sz == 0) return 0;
    for (i = 0; i < seg_cnt; i++) begin
      if (!seg_busy[i] && seg_len[i] >= sz) break;
      start += seg_len[i];
    end
    if (i >= seg_cnt) return 0;
    if (seg_len[i] == sz) begin
      seg_busy[i] = 1;
    end else begin
      if (seg_cnt >= NUM_SEG) return 0;
      for (int k = seg_cnt; k > i; k--) begin
        seg_len[k] = seg_len[k-1];
        seg_busy[k] = seg_busy[k-1];
      end
      seg_len[i] = sz;
      seg_busy[i] = 1;
      seg_len[i+1] -= sz;
      seg_cnt++;
    end
    off = start;
    return 1;
  endfunction

  function automatic void drop_segment(int k);
    for (int j = k; j + 1 < seg_cnt; j++) begin
      seg_len[j] = seg_len[j+1];
      seg_busy[j] = seg_busy[j+1];
    end
    seg_cnt--;
    seg_len[seg_cnt] = 0;
    seg_busy[seg_cnt] = 0;
  endfunction

  // release then merge, previous neighbour first
  function automatic bit release_segment(int off);
    int start, i;
    start = 0;
    for (i = 0; i < seg_cnt; i++) begin
      if (start == off) break;
      start += seg_len[i];
    end
    if (i >= seg_cnt) return 0;
    seg_busy[i] = 0;
    if (i > 0 && !seg_busy[i-1]) begin
      seg_len[i-1] += seg_len[i];
      drop_segment(i);
      i--;
    end
    if (i + 1 < seg_cnt && !seg_busy[i+1]) begin
      seg_len[i] += seg_len[i+1];
      drop_segment(i + 1);
    end
    return 1;
  endfunction

  function automatic grant_t serve_request(request_t r);
    grant_t g;
    int s, base, c, slot, off, fa;
    s = slots_eff();
    base = 3 * s;
    g.addr = '0;
    g.status = STAT_DONE;
    if (r.kind == REQ_ALLOC) begin
      c = (r.size == 2) ? 0 : (r.size == 4) ? 1 : (r.size == 8) ? 2 : -1;
      if (c >= 0 && take_slot(c, slot)) begin
        g.addr = 17'(c * s + slot);
      end else if (take_segment(int'(r.size), off)) begin
        g.addr = 17'(base + off);
      end else begin
        g.status = STAT_NO_SPACE;
      end
    end else begin
      fa = r.faddr;
      if (fa >= base + pool_eff()) begin
        g.status = STAT_IGNORED;
      end else if (fa < base) begin
        c = fa / s;
        slot = fa % s;
        slot_used[c][slot] = 0;
        hint_valid[c] = 1;
        hint_slot[c] = slot;
      end else if (!release_segment(fa - base)) begin
        g.status = STAT_IGNORED;
      end
    end
    return g;
  endfunction

  // mostly no gap, sometimes a few cycles, rarely a long one
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // request driver
  int src_gap = 0;
  always @(posedge clk_i) begin
    grant_t g;
    request_t cur;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        cur.kind = req_e'(s_axis_tuser);
        cur.size = s_axis_tdata[16:0];
        cur.faddr = s_axis_tdata[33:17];
        g = serve_request(cur);
        expected_grants.push_back(g);
        if (cur.kind == REQ_ALLOC && g.status == STAT_DONE) live_addrs.push_back(g.addr);
        reqs_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cur.kind;
          s_axis_tdata  <= {6'b0, cur.faddr, cur.size};
          src_gap = pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and back-pressure
  int sink_gap = 0;
  always @(posedge clk_i) begin
    grant_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        grants_seen++;
        if (expected_grants.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result item: addr %0d status %0d", m_axis_tdata[16:0],
                     m_axis_tuser);
        end else begin
          want = expected_grants.pop_front();
          case (want.status)
            STAT_DONE:     n_alloc_ok++;
            STAT_NO_SPACE: n_no_space++;
            default:       n_ignored++;
          endcase
          if (m_axis_tdata !== {7'b0, want.addr} || m_axis_tuser !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch on result %0d: expected addr %0d status %0d, got data %0h status %0d",
                       grants_seen, want.addr, want.status, m_axis_tdata, m_axis_tuser);
          end
        end
        sink_gap = pick_gap();
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired: %0d requests sent, %0d results seen", reqs_sent,
                 grants_seen);
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic push_req(req_e kind, int size, int faddr);
    request_t r;
    r.kind = kind;
    r.size = 17'(size);
    r.faddr = 17'(faddr);
    pending_reqs.push_back(r);
  endtask

  // wait for every expected result, then let the block settle
  task automatic drain();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_grants.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, int value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= 17'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_CACHE_SLOTS) cache_slots_q = value & 'h1FF;
    else pool_size_q = value & 'h1FFFF;
    restart_empty();
    cfg_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 45) begin
      case ($urandom_range(2))
        0: return 2;
        1: return 4;
        default: return 8;
      endcase
    end
    if (r < 80) return $urandom_range(64, 1);
    if (r < 92) return $urandom_range(pool_eff() + 4, 1);
    if (r < 95) return 0;
    return $urandom_range(17'h1FFFF);
  endfunction

  function automatic int pick_free_addr();
    int r, idx, a;
    r = $urandom_range(99);
    if (live_addrs.size() > 0 && r < 65) begin
      idx = $urandom_range(live_addrs.size() - 1);
      a = live_addrs[idx];
      live_addrs.delete(idx);
      return a;
    end
    if (live_addrs.size() > 0 && r < 72) return live_addrs[$urandom_range(live_addrs.size()-1)];
    if (r < 90) return $urandom_range(3 * slots_eff() + pool_eff());
    return $urandom_range(17'h1FFFF);
  endfunction

  // random traffic in short batches of up to ten, so frees can target live addresses
  task automatic random_phase(int count);
    int batch;
    while (count > 0) begin
      batch = (count < 10) ? count : 10;
      for (int i = 0; i < batch; i++) begin
        if ($urandom_range(99) < 55) push_req(REQ_ALLOC, pick_size(), $urandom_range(17'h1FFFF));
        else push_req(REQ_FREE, $urandom_range(17'h1FFFF), pick_free_addr());
      end
      count -= batch;
      while (pending_reqs.size() > 0) @(posedge clk_i);
    end
  endtask

  task automatic run_phase(int slots, int pool, int count);
    live_addrs.delete();
    write_cfg(CFG_CACHE_SLOTS, slots);
    write_cfg(CFG_POOL_SIZE, pool);
    no_idle = ($urandom_range(3) == 0);
    random_phase(count);
    drain();
  endtask

  initial begin
    restart_empty();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset configuration, slots 0..47, pool from 48
    push_req(REQ_ALLOC, 0, 0);            // size zero
    push_req(REQ_ALLOC, 2, 0);
    push_req(REQ_ALLOC, 4, 0);
    push_req(REQ_ALLOC, 8, 0);
    push_req(REQ_ALLOC, 2, 0);
    push_req(REQ_FREE, 0, 0);             // slot free sets the hint
    push_req(REQ_FREE, 0, 0);             // double free of a slot
    push_req(REQ_ALLOC, 2, 0);            // taken through the hint
    push_req(REQ_ALLOC, 100, 17'h1FFFF);
    push_req(REQ_ALLOC, 1, 0);
    push_req(REQ_ALLOC, 65536, 0);        // no fitting segment
    push_req(REQ_ALLOC, 17'h1FFFF, 0);
    push_req(REQ_FREE, 0, 49);            // not at a segment start
    push_req(REQ_FREE, 0, 48);            // frees the 100-byte segment
    push_req(REQ_FREE, 0, 48);            // free of a free segment, its busy neighbour keeps it from merging
    push_req(REQ_FREE, 0, 48 + 4096);     // just past the arena
    push_req(REQ_FREE, 0, 17'h1FFFF);
    push_req(REQ_ALLOC, 4096, 0);
    drain();

    // one slot per class and a 64-byte pool: a class fills up, then small pool allocs
    write_cfg(CFG_CACHE_SLOTS, 1);
    write_cfg(CFG_POOL_SIZE, 64);
    push_req(REQ_ALLOC, 8, 0);
    push_req(REQ_ALLOC, 8, 0);            // class full, falls to the pool
    for (int i = 0; i < 5; i++) push_req(REQ_ALLOC, 3, 0);
    drain();

    // class region size zero and a tiny pool, then the table filled up
    write_cfg(CFG_CACHE_SLOTS, 0);
    write_cfg(CFG_POOL_SIZE, 0);
    push_req(REQ_ALLOC, 2, 0);
    push_req(REQ_ALLOC, 1, 0);
    drain();
    write_cfg(CFG_POOL_SIZE, 256);
    for (int i = 0; i < 17; i++) push_req(REQ_ALLOC, 1, 0);
    drain();

    run_phase(16, 4096, 110);
    run_phase(0, 256, 100);
    run_phase(256, 65536, 110);
    run_phase(1, 1, 80);
    run_phase(17'h1FF, 17'h1FFFF, 110);   // both clamped
    run_phase(3, 40, 120);
    run_phase(8, 200, 120);
    drain();

    $display("covered %0d requests over %0d register writes: %0d served, %0d no space, %0d ignored",
             reqs_sent, cfg_writes, n_alloc_ok, n_no_space, n_ignored);
    if (mismatches == 0 && expected_grants.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_grants.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/ffsa_pkg.sv
hw/rtl/ffsa_ram.sv
hw/rtl/ffsa_seg_tbl.sv
hw/rtl/first_fit_segment_allocator_core.sv
hw/rtl/ffsa_checker.sv
test/first_fit_segment_allocator_core_test.sv
